[src/stp_pkg.sv]
// ----------------------------------------------------------------------------
// stp_pkg - shared types and constants for the scan tangent point selector
// Holds the cost format, register map codes and the sequencer program table.
// ----------------------------------------------------------------------------
`default_nettype none

package stp_pkg;

	// Score format: unsigned Q18.0, saturating
	localparam int COST_BITS = 18;
	localparam logic [COST_BITS-1:0] COST_MAX = '1;

	// Configuration register indexes (byte address / 4)
	localparam logic [1:0] REG_VEHICLE_X = 2'd0;
	localparam logic [1:0] REG_VEHICLE_Y = 2'd1;
	localparam logic [1:0] REG_GOAL_X    = 2'd2;
	localparam logic [1:0] REG_GOAL_Y    = 2'd3;

	// Datapath operation selected by a control word
	typedef enum logic [3:0] {
		OP_NOP,
		OP_WAIT,
		OP_READ,
		OP_EDGE,
		OP_DIFF_V,
		OP_DIFF_G,
		OP_SQUARE,
		OP_ROOT,
		OP_HOLD,
		OP_SCORE,
		OP_EMIT
	} uop_t;

	// Jump condition; the jump is taken when the condition holds
	typedef enum logic [2:0] {
		CD_NEXT,
		CD_ALWAYS,
		CD_NO_ITEM,
		CD_NO_TANGENT,
		CD_ROOT_MORE,
		CD_NOT_END,
		CD_OUT_BUSY
	} cond_t;

	typedef logic [3:0] pc_t;

	typedef struct packed {
		uop_t  op;
		cond_t cond;
		pc_t   target;
	} uword_t;

	// Program step addresses
	localparam pc_t PC_WAIT   = 4'd0;
	localparam pc_t PC_READ   = 4'd1;
	localparam pc_t PC_EDGE   = 4'd2;
	localparam pc_t PC_DIFF1  = 4'd3;
	localparam pc_t PC_SQ1    = 4'd4;
	localparam pc_t PC_ROOT1  = 4'd5;
	localparam pc_t PC_HOLD   = 4'd6;
	localparam pc_t PC_DIFF2  = 4'd7;
	localparam pc_t PC_SQ2    = 4'd8;
	localparam pc_t PC_ROOT2  = 4'd9;
	localparam pc_t PC_SCORE  = 4'd10;
	localparam pc_t PC_TAIL   = 4'd11;
	localparam pc_t PC_EMIT   = 4'd12;
	localparam pc_t PC_RETURN = 4'd13;

	// Sequencer program: one control word per step
	function automatic uword_t ucode(input pc_t pc);
		uword_t w;
		unique case (pc)
			PC_WAIT:   w = '{OP_WAIT,   CD_NO_ITEM,    PC_WAIT};
			PC_READ:   w = '{OP_READ,   CD_NEXT,       PC_WAIT};
			PC_EDGE:   w = '{OP_EDGE,   CD_NO_TANGENT, PC_TAIL};
			PC_DIFF1:  w = '{OP_DIFF_V, CD_NEXT,       PC_WAIT};
			PC_SQ1:    w = '{OP_SQUARE, CD_NEXT,       PC_WAIT};
			PC_ROOT1:  w = '{OP_ROOT,   CD_ROOT_MORE,  PC_ROOT1};
			PC_HOLD:   w = '{OP_HOLD,   CD_NEXT,       PC_WAIT};
			PC_DIFF2:  w = '{OP_DIFF_G, CD_NEXT,       PC_WAIT};
			PC_SQ2:    w = '{OP_SQUARE, CD_NEXT,       PC_WAIT};
			PC_ROOT2:  w = '{OP_ROOT,   CD_ROOT_MORE,  PC_ROOT2};
			PC_SCORE:  w = '{OP_SCORE,  CD_NEXT,       PC_WAIT};
			PC_TAIL:   w = '{OP_NOP,    CD_NOT_END,    PC_WAIT};
			PC_EMIT:   w = '{OP_EMIT,   CD_OUT_BUSY,   PC_EMIT};
			PC_RETURN: w = '{OP_NOP,    CD_ALWAYS,     PC_WAIT};
			default:   w = '{OP_NOP,    CD_ALWAYS,     PC_WAIT};
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

[src/stp_ram.sv]
// ----------------------------------------------------------------------------
// stp_ram - generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; contents are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module stp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 10,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

[src/scan_tangent_point_select.sv]
// ----------------------------------------------------------------------------
// scan_tangent_point_select - tangent point selection over a range scan
// Finds occupancy edges between each point and the point WINDOW places
// earlier, scores each tangent point by vehicle and goal distance, and
// reports the lowest score when a scan ends.
//
//   Channel   Direction  Handshake            Payload
//   in        sink       in_valid / in_stall  point_x, point_y, scan_end
//   out       source     out_valid/out_stall  best_x, best_y, best_cost,
//                                             found, obstacle_seen
//   config    APB slave  psel/penable/pready  four position registers
//
// An item with a tangent point runs longer than one without, set by the
// shared square root unit, which yields one root bit per cycle for two
// distances in turn.
// A scan-end item adds emit and return steps and waits while a previous result is held.
// Reset clears the sequencer, scan state and registers; the window RAM is
// not cleared, as the fill count gates every use of the data read from it.
// ----------------------------------------------------------------------------
`default_nettype none

module scan_tangent_point_select #(
	parameter int WINDOW     = 10,
	parameter int COORD_BITS = 16
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// Point input
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire logic signed [COORD_BITS-1:0]       point_x,
	input  wire logic signed [COORD_BITS-1:0]       point_y,
	input  wire logic                               scan_end,
	// Result output
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output logic signed [COORD_BITS-1:0]            best_x,
	output logic signed [COORD_BITS-1:0]            best_y,
	output logic [stp_pkg::COST_BITS-1:0]           best_cost,
	output logic                                    found,
	output logic                                    obstacle_seen,
	// Configuration
	input  wire logic                               psel,
	input  wire logic                               penable,
	input  wire logic                               pwrite,
	input  wire logic [3:0]                         paddr,
	input  wire logic [31:0]                        pwdata,
	output logic [31:0]                             prdata,
	output logic                                    pready
);

	import stp_pkg::*;

	localparam int C    = COORD_BITS;
	localparam int AW   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int FW   = $clog2(WINDOW + 1);
	localparam int DW   = C + 1;       // coordinate difference
	localparam int RW   = 2 * C + 2;   // sum of squares
	localparam int RTW  = C + 1;       // root
	localparam int REMW = C + 2;       // root remainder
	localparam int CW   = $clog2(C + 2);

	// Configuration registers
	logic signed [C-1:0] veh_x_q, veh_y_q, goal_x_q, goal_y_q;

	// Sequencer
	pc_t    pc_q;
	uword_t uw;
	logic   jump;

	// Item and scan state
	logic signed [C-1:0] px_q, py_q, tx_q, ty_q, bx_q, by_q;
	logic                end_q;
	logic [AW-1:0]       wr_ptr_q;
	logic [FW-1:0]       fill_q;
	logic [COST_BITS-1:0] best_score_q;
	logic                found_q, obstacle_q;

	// Distance datapath
	logic signed [DW-1:0] dx_q, dy_q;
	logic [RW-1:0]        rad_q;
	logic [REMW-1:0]      rem_q;
	logic [RTW-1:0]       root_q, d1_q;
	logic [CW-1:0]        root_cnt_q;

	// Output register
	logic                 out_valid_q;
	logic signed [C-1:0]  out_x_q, out_y_q;
	logic [COST_BITS-1:0] out_cost_q;
	logic                 out_found_q, out_obst_q;

	logic [2*C-1:0] ram_rdata;
	logic           in_take, out_busy, cfg_wr;

	assign uw       = ucode(pc_q);
	assign in_stall = (uw.op != OP_WAIT);
	assign in_take  = in_valid & ~in_stall;
	assign out_busy = out_valid_q & out_stall;
	assign cfg_wr   = psel & penable & pwrite & pready;
	assign pready   = 1'b1;

	// Configuration write and read-back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			veh_x_q  <= '0;
			veh_y_q  <= '0;
			goal_x_q <= '0;
			goal_y_q <= '0;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_VEHICLE_X: veh_x_q  <= pwdata[C-1:0];
				REG_VEHICLE_Y: veh_y_q  <= pwdata[C-1:0];
				REG_GOAL_X:    goal_x_q <= pwdata[C-1:0];
				REG_GOAL_Y:    goal_y_q <= pwdata[C-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_VEHICLE_X: prdata = 32'(veh_x_q);
			REG_VEHICLE_Y: prdata = 32'(veh_y_q);
			REG_GOAL_X:    prdata = 32'(goal_x_q);
			REG_GOAL_Y:    prdata = 32'(goal_y_q);
		endcase
	end

	// Window delay line
	stp_ram #(
		.WIDTH (2 * C),
		.DEPTH (WINDOW),
		.AW    (AW)
	) u_window (
		.clk   (clk),
		.we    (uw.op == OP_EDGE),
		.waddr (wr_ptr_q),
		.wdata ({px_q, py_q}),
		.re    (uw.op == OP_READ),
		.raddr (wr_ptr_q),
		.rdata (ram_rdata)
	);

	// Edge detection against the point WINDOW places back
	logic signed [C-1:0] q_x, q_y;
	logic win_full, q_full, q_empty, p_full, p_empty, tan_fall, tan_rise, tan_hit;

	assign q_x      = ram_rdata[2*C-1:C];
	assign q_y      = ram_rdata[C-1:0];
	assign win_full = (fill_q == FW'(WINDOW));
	assign q_full   = (q_x != '0) && (q_y != '0);
	assign q_empty  = (q_x == '0) && (q_y == '0);
	assign p_full   = (px_q != '0) && (py_q != '0);
	assign p_empty  = (px_q == '0) && (py_q == '0);
	assign tan_fall = win_full & q_full & p_empty;
	assign tan_rise = win_full & q_empty & p_full;
	assign tan_hit  = tan_fall | tan_rise;

	// Squares and one root digit step
	logic signed [RW-1:0] sq_x, sq_y;
	logic [REMW+1:0]      rem_cur, root_trial, rem_diff;
	logic                 root_ge;

	assign sq_x       = dx_q * dx_q;
	assign sq_y       = dy_q * dy_q;
	assign rem_cur    = {rem_q, rad_q[RW-1 -: 2]};
	assign root_trial = {1'b0, root_q, 2'b01};
	assign root_ge    = (rem_cur >= root_trial);
	assign rem_diff   = rem_cur - root_trial;

	// Score: saturated sum of both distances
	logic [31:0]          cost_sum;
	logic [COST_BITS-1:0] cost_sat;

	assign cost_sum = 32'(d1_q) + 32'(root_q);
	assign cost_sat = (cost_sum > 32'(COST_MAX)) ? COST_MAX : cost_sum[COST_BITS-1:0];

	// Evaluate the jump condition of the current step
	always_comb begin
		unique case (uw.cond)
			CD_NEXT:       jump = 1'b0;
			CD_ALWAYS:     jump = 1'b1;
			CD_NO_ITEM:    jump = ~in_valid;
			CD_NO_TANGENT: jump = ~tan_hit;
			CD_ROOT_MORE:  jump = (root_cnt_q != CW'(1));
			CD_NOT_END:    jump = ~end_q;
			CD_OUT_BUSY:   jump = out_busy;
			default:       jump = 1'b1;
		endcase
	end

	// Sequencer, scan state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q         <= PC_WAIT;
			wr_ptr_q     <= '0;
			fill_q       <= '0;
			best_score_q <= COST_MAX;
			found_q      <= 1'b0;
			obstacle_q   <= 1'b0;
			root_cnt_q   <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			pc_q <= jump ? uw.target : pc_q + 4'd1;

			// Raise the result on emit, hold it while stalled, drop it once taken
			out_valid_q <= (uw.op == OP_EMIT && !out_busy) | out_busy;

			unique case (uw.op)
				OP_WAIT: begin
					if (in_take && (point_x != '0 || point_y != '0)) begin
						obstacle_q <= 1'b1;
					end
				end
				OP_EDGE: begin
					wr_ptr_q <= (wr_ptr_q == AW'(WINDOW - 1)) ? '0 : wr_ptr_q + 1'b1;
					if (!win_full) begin
						fill_q <= fill_q + 1'b1;
					end
				end
				OP_SQUARE: root_cnt_q <= CW'(RTW);
				OP_ROOT:   root_cnt_q <= root_cnt_q - 1'b1;
				OP_SCORE: begin
					if (!found_q || cost_sat < best_score_q) begin
						best_score_q <= cost_sat;
						found_q      <= 1'b1;
					end
				end
				OP_EMIT: begin
					if (!out_busy) begin
						wr_ptr_q     <= '0;
						fill_q       <= '0;
						best_score_q <= COST_MAX;
						found_q      <= 1'b0;
						obstacle_q   <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		unique case (uw.op)
			OP_WAIT: begin
				if (in_take) begin
					px_q  <= point_x;
					py_q  <= point_y;
					end_q <= scan_end;
				end
			end
			OP_EDGE: begin
				tx_q <= tan_fall ? q_x : px_q;
				ty_q <= tan_fall ? q_y : py_q;
			end
			OP_DIFF_V: begin
				dx_q <= $signed({tx_q[C-1], tx_q}) - $signed({veh_x_q[C-1], veh_x_q});
				dy_q <= $signed({ty_q[C-1], ty_q}) - $signed({veh_y_q[C-1], veh_y_q});
			end
			OP_DIFF_G: begin
				dx_q <= $signed({tx_q[C-1], tx_q}) - $signed({goal_x_q[C-1], goal_x_q});
				dy_q <= $signed({ty_q[C-1], ty_q}) - $signed({goal_y_q[C-1], goal_y_q});
			end
			OP_SQUARE: begin
				rad_q  <= $unsigned(sq_x) + $unsigned(sq_y);
				rem_q  <= '0;
				root_q <= '0;
			end
			OP_ROOT: begin
				rad_q  <= {rad_q[RW-3:0], 2'b00};
				rem_q  <= root_ge ? rem_diff[REMW-1:0] : rem_cur[REMW-1:0];
				root_q <= {root_q[RTW-2:0], root_ge};
			end
			OP_HOLD: d1_q <= root_q;
			OP_SCORE: begin
				if (!found_q || cost_sat < best_score_q) begin
					bx_q <= tx_q;
					by_q <= ty_q;
				end
			end
			OP_EMIT: begin
				if (!out_busy) begin
					out_x_q     <= found_q ? bx_q : '0;
					out_y_q     <= found_q ? by_q : '0;
					out_cost_q  <= found_q ? best_score_q : '0;
					out_found_q <= found_q;
					out_obst_q  <= obstacle_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid     = out_valid_q;
	assign best_x        = out_x_q;
	assign best_y        = out_y_q;
	assign best_cost     = out_cost_q;
	assign found         = out_found_q;
	assign obstacle_seen = out_obst_q;

	// Fill count never passes the window depth
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FW'(WINDOW))
		else $error("window fill count beyond depth");

	// Write pointer stays inside the window
	a_ptr_bound: assert property (@(posedge clk) disable iff (!arst_n)
		wr_ptr_q <= AW'(WINDOW - 1))
		else $error("window pointer out of range");

	// No tangent recorded means the score is still at its ceiling
	a_empty_score: assert property (@(posedge clk) disable iff (!arst_n)
		!found_q |-> best_score_q == COST_MAX)
		else $error("score moved without a tangent point");

	// Root loop never runs with an exhausted digit count
	a_root_count: assert property (@(posedge clk) disable iff (!arst_n)
		uw.op == OP_ROOT |-> root_cnt_q != '0)
		else $error("root step with no digits left");

	// A result is only formed for a scan-end item
	a_emit_end: assert property (@(posedge clk) disable iff (!arst_n)
		(uw.op == OP_EMIT && !out_busy) |=> out_valid_q && $past(end_q))
		else $error("result formed without scan end");

endmodule

`default_nettype wire

[test/scan_tangent_point_select_test.sv]
// ----------------------------------------------------------------------------
// scan_tangent_point_select_test - regression for the tangent point selector
// Drives range scans through the point channel and checks every scan-end
// result against a table entry or an in-bench model of the window, edge
// detection and distance scoring. Registers are rewritten between phases
// over the whole coordinate range, and both channels idle and stall at random.
// ----------------------------------------------------------------------------

module scan_tangent_point_select_test;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int WINDOW     = 10;
	localparam int COORD_BITS = 16;
	localparam int SETTLE     = 64;  // cycles a tangent item plus emit may still run
	localparam int BLOCKS     = 8;
	localparam int BLOCK_ITEMS = 190;
	localparam int HOLD_CYCLES = 3000;

	typedef logic signed [COORD_BITS-1:0] coord_t;

	typedef struct packed {
		coord_t                        x;
		coord_t                        y;
		logic [stp_pkg::COST_BITS-1:0] cost;
		logic                          found;
		logic                          obstacle;
	} scan_result_t;

	typedef struct packed {
		coord_t       x;
		coord_t       y;
		logic         last;
		logic [7:0]   reps;
		logic         typed;
		scan_result_t want;
	} scan_row_t;

	typedef enum {PK_EMPTY, PK_FULL, PK_MIXED, PK_ANY} point_kind_t;

	// Ports
	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	coord_t point_x;
	coord_t point_y;
	logic scan_end;
	logic out_valid;
	logic out_stall;
	coord_t best_x;
	coord_t best_y;
	logic [stp_pkg::COST_BITS-1:0] best_cost;
	logic found;
	logic obstacle_seen;
	logic psel;
	logic penable;
	logic pwrite;
	logic [3:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	// Model state: registers and scan
	int cfg_vx, cfg_vy, cfg_gx, cfg_gy;
	coord_t win_x [WINDOW];
	coord_t win_y [WINDOW];
	int win_slot, win_fill;
	coord_t lead_x, lead_y;
	longint unsigned lead_cost;
	bit tangent_seen, return_seen;

	scan_result_t awaited_results [$];

	int tx_idle_pct, rx_idle_pct;
	int hold_requests, hold_served;
	int mismatch_count, results_checked, items_sent, scans_sent, reg_writes;

	// Directed scans: reset values, extremes, mixed point, both edge kinds
	scan_row_t directed [7] = '{
		'{16'sh0000, 16'sh0000, 1'b1, 8'd1,  1'b1, '{16'sh0, 16'sh0, 18'd0,  1'b0, 1'b0}},
		'{16'sh7fff, 16'sh8000, 1'b1, 8'd1,  1'b1, '{16'sh0, 16'sh0, 18'd0,  1'b0, 1'b1}},
		'{16'sh0000, 16'shffff, 1'b1, 8'd1,  1'b1, '{16'sh0, 16'sh0, 18'd0,  1'b0, 1'b1}},
		'{16'sh0003, 16'sh0004, 1'b0, 8'd10, 1'b0, '0},
		'{16'sh0000, 16'sh0000, 1'b1, 8'd1,  1'b1, '{16'sh3, 16'sh4, 18'd10, 1'b1, 1'b1}},
		'{16'sh0000, 16'sh0000, 1'b0, 8'd10, 1'b0, '0},
		'{16'sh8000, 16'sh8000, 1'b1, 8'd1,  1'b0, '0}
	};

	scan_tangent_point_select DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.point_x       (point_x),
		.point_y       (point_y),
		.scan_end      (scan_end),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.best_x        (best_x),
		.best_y        (best_y),
		.best_cost     (best_cost),
		.found         (found),
		.obstacle_seen (obstacle_seen),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	always #5 clk = ~clk;

	task automatic flag_mismatch(input string msg);
		if (mismatch_count < 40)
			$display("MISMATCH @%0t: %s", $time, msg);
		mismatch_count++;
	endtask

	// Integer square root, floor, one result bit per pass
	function automatic longint unsigned root_floor(input longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'h4000_0000_0000_0000;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint unsigned span(input int ax, ay, bx, by);
		int dx, dy;
		longint unsigned ux, uy;
		dx = ax - bx;
		dy = ay - by;
		ux = (dx < 0) ? -dx : dx;
		uy = (dy < 0) ? -dy : dy;
		return root_floor(ux * ux + uy * uy);
	endfunction

	task automatic clear_scan();
		foreach (win_x[i]) begin
			win_x[i] = '0;
			win_y[i] = '0;
		end
		win_slot = 0;
		win_fill = 0;
		lead_x = '0;
		lead_y = '0;
		lead_cost = stp_pkg::COST_MAX;
		tangent_seen = 0;
		return_seen = 0;
	endtask

	// Score a tangent point; keep it only if strictly better or the first
	task automatic weigh_tangent(input coord_t tx, ty);
		longint unsigned c;
		c = span(cfg_vx, cfg_vy, tx, ty) + span(tx, ty, cfg_gx, cfg_gy);
		if (c > stp_pkg::COST_MAX)
			c = stp_pkg::COST_MAX;
		if (!tangent_seen || c < lead_cost) begin
			lead_x = tx;
			lead_y = ty;
			lead_cost = c;
			tangent_seen = 1;
		end
	endtask

	// Advance the scan model by one point; a scan end yields a result
	task automatic take_point(input coord_t px, py, input bit last,
			output bit emits, output scan_result_t res);
		coord_t qx, qy;
		bit q_full, q_empty, p_full, p_empty;
		if (px != 0 || py != 0)
			return_seen = 1;
		if (win_fill >= WINDOW) begin
			qx = win_x[win_slot];
			qy = win_y[win_slot];
			q_full = (qx != 0) && (qy != 0);
			q_empty = (qx == 0) && (qy == 0);
			p_full = (px != 0) && (py != 0);
			p_empty = (px == 0) && (py == 0);
			if (q_full && p_empty)
				weigh_tangent(qx, qy);
			else if (q_empty && p_full)
				weigh_tangent(px, py);
		end else begin
			win_fill++;
		end
		win_x[win_slot] = px;
		win_y[win_slot] = py;
		win_slot = (win_slot + 1 == WINDOW) ? 0 : win_slot + 1;
		emits = last;
		res = '0;
		if (last) begin
			if (tangent_seen) begin
				res.x = lead_x;
				res.y = lead_y;
				res.cost = lead_cost[stp_pkg::COST_BITS-1:0];
			end
			res.found = tangent_seen;
			res.obstacle = return_seen;
			clear_scan();
		end
	endtask

	// Offer one item; entered and left at a falling edge, valid left high
	task automatic send_point(input coord_t x, y, input bit last, input bit typed,
			input scan_result_t want);
		bit emits;
		scan_result_t res;
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		point_x = x;
		point_y = y;
		scan_end = last;
		do
			@(posedge clk);
		while (in_stall);
		take_point(x, y, last, emits, res);
		if (emits)
			awaited_results.insert(awaited_results.size(), typed ? want : res);
		items_sent++;
		@(negedge clk);
	endtask

	// Write a register, then read it back
	task automatic set_register(input logic [1:0] idx, input logic [15:0] value);
		logic [31:0] word;
		word = $urandom();
		word[15:0] = value;
		psel = 1'b1;
		pwrite = 1'b1;
		penable = 1'b0;
		paddr = {idx, 2'b00};
		pwdata = word;
		@(negedge clk);
		penable = 1'b1;
		do
			@(posedge clk);
		while (!pready);
		@(negedge clk);
		pwrite = 1'b0;
		penable = 1'b0;
		@(negedge clk);
		penable = 1'b1;
		do
			@(posedge clk);
		while (!pready);
		if (prdata[15:0] !== value)
			flag_mismatch($sformatf("register %0d reads %h, wrote %h", idx, prdata[15:0], value));
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		unique case (idx)
			stp_pkg::REG_VEHICLE_X: cfg_vx = $signed(value);
			stp_pkg::REG_VEHICLE_Y: cfg_vy = $signed(value);
			stp_pkg::REG_GOAL_X:    cfg_gx = $signed(value);
			stp_pkg::REG_GOAL_Y:    cfg_gy = $signed(value);
		endcase
		reg_writes++;
	endtask

	// Drop valid and wait until every result is in and the block is quiet
	task automatic drain();
		in_valid = 1'b0;
		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		@(negedge clk);
	endtask

	function automatic coord_t rand_nonzero();
		coord_t c;
		case ($urandom_range(9))
			0: c = 16'sh7fff;
			1: c = 16'sh8000;
			2: c = 16'sh0001;
			3: c = 16'shffff;
			default: begin
				c = coord_t'($urandom());
				if (c == 0)
					c = 16'sh0001;
			end
		endcase
		return c;
	endfunction

	task automatic pick_point(input point_kind_t kind, input bit tie, output coord_t x, y);
		case (kind)
			PK_EMPTY: begin
				x = '0;
				y = '0;
			end
			PK_FULL: begin
				// a small pool of points at equal distance from the origin gives ties when vehicle and goal sit there
				if (tie) begin
					case ($urandom_range(4))
						0: begin x = 16'sd3;  y = 16'sd4;  end
						1: begin x = 16'sd4;  y = 16'sd3;  end
						2: begin x = -16'sd3; y = 16'sd4;  end
						3: begin x = 16'sd3;  y = -16'sd4; end
						default: begin x = -16'sd4; y = -16'sd3; end
					endcase
				end else begin
					x = rand_nonzero();
					y = rand_nonzero();
				end
			end
			PK_MIXED: begin
				x = rand_nonzero();
				y = '0;
				if ($urandom_range(1)) begin
					y = x;
					x = '0;
				end
			end
			default: begin
				x = ($urandom_range(3) == 0) ? 16'sh0 : rand_nonzero();
				y = ($urandom_range(3) == 0) ? 16'sh0 : rand_nonzero();
			end
		endcase
	endtask

	// One scan: mostly runs of empty and full points, some noise, some short
	task automatic send_scan();
		int n, mode, left, r;
		bit tie;
		point_kind_t kind;
		coord_t x, y;
		mode = $urandom_range(99);
		tie = ($urandom_range(4) == 0);
		n = (mode < 10) ? $urandom_range(9, 1) : $urandom_range(70, 11);
		left = 0;
		kind = PK_EMPTY;
		for (int i = 0; i < n; i++) begin
			if (mode < 25) begin
				kind = PK_ANY;
			end else if (left == 0) begin
				r = $urandom_range(9);
				kind = (r < 4) ? PK_EMPTY : (r < 9) ? PK_FULL : PK_MIXED;
				left = $urandom_range(16, 1);
			end
			if (left > 0)
				left--;
			pick_point(kind, tie, x, y);
			send_point(x, y, i == n - 1, 1'b0, '0);
		end
		scans_sent++;
	endtask

	function automatic logic [15:0] rand_reg();
		case ($urandom_range(5))
			0: return 16'h8000;
			1: return 16'h7fff;
			default: return 16'($urandom());
		endcase
	endfunction

	// Receiver: random stall, or a long hold-off when one is asked for
	initial begin
		int left;
		out_stall = 1'b0;
		left = 0;
		forever begin
			@(negedge clk);
			if (left == 0 && hold_served != hold_requests) begin
				hold_served = hold_requests;
				left = HOLD_CYCLES;
			end
			if (left > 0) begin
				out_stall = 1'b1;
				left--;
			end else begin
				out_stall = ($urandom_range(99) < rx_idle_pct);
			end
		end
	end

	// Check each accepted result against the oldest expectation
	always @(posedge clk) begin
		scan_result_t got, want;
		if (arst_n && out_valid && !out_stall) begin
			got = '{best_x, best_y, best_cost, found, obstacle_seen};
			if (awaited_results.size() == 0) begin
				flag_mismatch($sformatf("unexpected result x=%0d y=%0d cost=%0d",
					best_x, best_y, best_cost));
			end else begin
				want = awaited_results.pop_front();
				if (got !== want)
					flag_mismatch($sformatf(
						"got x=%0d y=%0d cost=%0d f=%b o=%b, want x=%0d y=%0d cost=%0d f=%b o=%b",
						got.x, got.y, got.cost, got.found, got.obstacle,
						want.x, want.y, want.cost, want.found, want.obstacle));
				results_checked++;
			end
		end
	end

	// Give up on a hung run
	initial begin
		#5_000_000;
		$display("scan_tangent_point_select regression: fail");
		$finish;
	end

	initial begin
		logic [15:0] vx, vy, gx, gy;
		int start;
		arst_n = 1'b0;
		in_valid = 1'b0;
		point_x = '0;
		point_y = '0;
		scan_end = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		tx_idle_pct = 13;
		rx_idle_pct = 58;
		hold_requests = 0;
		hold_served = 0;
		cfg_vx = 0;
		cfg_vy = 0;
		cfg_gx = 0;
		cfg_gy = 0;
		clear_scan();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed scans with registers at reset
		foreach (directed[i])
			for (int k = 0; k < directed[i].reps; k++)
				send_point(directed[i].x, directed[i].y, directed[i].last,
					directed[i].typed, directed[i].want);

		// Random scans in phases of register setting and idling
		for (int blk = 0; blk < BLOCKS; blk++) begin
			drain();
			tx_idle_pct = (blk < 3) ? 13 : (blk < 6) ? 58 : 0;
			rx_idle_pct = (blk < 3) ? 58 : (blk < 6) ? 13 : 0;
			case (blk)
				0: begin vx = 16'h8000; vy = 16'h8000; gx = 16'h8000; gy = 16'h8000; end
				1: begin vx = 16'h7fff; vy = 16'h7fff; gx = 16'h7fff; gy = 16'h7fff; end
				2: begin vx = 16'h8000; vy = 16'h8000; gx = 16'h7fff; gy = 16'h7fff; end
				3: begin vx = 16'h0000; vy = 16'h0000; gx = 16'h0000; gy = 16'h0000; end
				default: begin vx = rand_reg(); vy = rand_reg(); gx = rand_reg(); gy = rand_reg(); end
			endcase
			set_register(stp_pkg::REG_VEHICLE_X, vx);
			set_register(stp_pkg::REG_VEHICLE_Y, vy);
			set_register(stp_pkg::REG_GOAL_X, gx);
			set_register(stp_pkg::REG_GOAL_Y, gy);
			// hold results back while points keep coming, so the input backs up
			if (blk == BLOCKS - 2)
				hold_requests++;
			start = items_sent;
			while (items_sent - start < BLOCK_ITEMS)
				send_scan();
		end
		drain();

		$display("covered %0d points in %0d random scans plus directed, %0d results checked",
			items_sent, scans_sent, results_checked);
		$display("%0d register writes over extreme and random positions, one long output hold",
			reg_writes);
		if (mismatch_count == 0)
			$display("scan_tangent_point_select regression: pass");
		else
			$display("scan_tangent_point_select regression: fail");
		$finish;
	end

endmodule

[filelist.f]
src/stp_pkg.sv
src/stp_ram.sv
src/scan_tangent_point_select.sv
test/scan_tangent_point_select_test.sv
